@@ rtl/cfe_pkg.sv @@
package cfe_pkg;

    localparam int BUCKET_COUNT = 128;
    localparam int IDX_W        = $clog2(BUCKET_COUNT);
    localparam int FP_W         = 16;
    localparam int KEY_W        = 16;
    localparam int RELOC_W      = 8;
    localparam int CMD_DEPTH    = 2;

    localparam logic [FP_W-1:0] HASH_SEED  = 16'd5381;
    localparam int              HASH_SHIFT = 5;
    localparam int              BYTE_W     = 8;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [FP_W-1:0]  fp_t;

    typedef struct packed {
        logic              kind;
        logic [KEY_W-1:0]  key;
        logic              victim_pick;
    } in_item_t;

    typedef struct packed {
        logic               ok;
        logic [RELOC_W-1:0] relocations;
    } out_item_t;

    typedef struct packed {
        logic kind;
        logic pick;
        fp_t  fp;
        idx_t cur;
        idx_t alt;
    } cmd_t;

    // 16-bit djb hash of two bytes, low byte first; all sums wrap at 16 bits.
    function automatic fp_t djb16(input logic [KEY_W-1:0] v);
        fp_t h;
        h = HASH_SEED;
        h = (h << HASH_SHIFT) + h + {{(FP_W-BYTE_W){1'b0}}, v[BYTE_W-1:0]};
        h = (h << HASH_SHIFT) + h + {{(FP_W-BYTE_W){1'b0}}, v[2*BYTE_W-1:BYTE_W]};
        return h;
    endfunction

    // Bucket index of a value: the hash taken modulo the power-of-two bucket count.
    function automatic idx_t index_of(input logic [KEY_W-1:0] v);
        fp_t h;
        h = djb16(v);
        return h[IDX_W-1:0];
    endfunction

endpackage

@@ rtl/cfe_ram.sv @@
module cfe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/cfe_front.sv @@
module cfe_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cfe_pkg::in_item_t item,
    output logic             full,
    output logic             cmd_valid,
    output cfe_pkg::cmd_t    cmd,
    input  logic             cmd_pop
);
    import cfe_pkg::*;

    localparam int PTR_W = $clog2(CMD_DEPTH);

    cmd_t             entry_reg [CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    cmd_t             new_cmd;
    logic             do_push;
    logic             do_pop;

    // Hash the key on the way in so the back end sees ready-made indexes.
    always_comb
    begin
        new_cmd.kind = item.kind;
        new_cmd.pick = item.victim_pick;
        new_cmd.fp   = djb16(item.key);
        new_cmd.cur  = new_cmd.fp[IDX_W-1:0];
        new_cmd.alt  = new_cmd.cur ^ index_of(new_cmd.fp);
    end

    assign full      = (count_reg == (PTR_W+1)'(CMD_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

@@ rtl/cfe_back.sv @@
module cfe_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    input  cfe_pkg::cmd_t                cmd,
    output logic                         cmd_pop,
    input  logic [cfe_pkg::RELOC_W-1:0]  reloc_limit,
    output logic                         empty,
    output cfe_pkg::out_item_t           result,
    input  logic                         pop
);
    import cfe_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CUR,
        S_ALT,
        S_REL_CHK,
        S_REL_RD
    } state_t;

    state_t               state_reg, state_next;
    logic                 kind_reg, kind_next;
    logic                 pick_reg, pick_next;
    fp_t                  fp_reg, fp_next;
    idx_t                 cur_reg, cur_next;
    idx_t                 alt_reg, alt_next;
    fp_t                  cur_val_reg, cur_val_next;
    logic [RELOC_W-1:0]   cnt_reg, cnt_next;
    logic [BUCKET_COUNT-1:0] valid_reg, valid_next;
    logic                 valid_rd_reg, valid_rd_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_reg, out_next;

    logic  ram_we;
    idx_t  ram_waddr;
    fp_t   ram_wdata;
    idx_t  ram_raddr;
    fp_t   ram_rdata;
    fp_t   rd_slot;
    idx_t  nxt_idx;

    cfe_ram #(
        .WIDTH(FP_W),
        .DEPTH(BUCKET_COUNT)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // A bucket never written since reset reads as empty.
    assign rd_slot = valid_rd_reg ? ram_rdata : '0;
    assign nxt_idx = cur_reg ^ index_of(fp_reg);
    assign empty   = !out_valid_reg;
    assign result  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        pick_next      = pick_reg;
        fp_next        = fp_reg;
        cur_next       = cur_reg;
        alt_next       = alt_reg;
        cur_val_next   = cur_val_reg;
        cnt_next       = cnt_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        cmd_pop        = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = cur_reg;
        ram_wdata      = fp_reg;
        ram_raddr      = cur_reg;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && !out_valid_reg)
                begin
                    cmd_pop    = 1'b1;
                    kind_next  = cmd.kind;
                    pick_next  = cmd.pick;
                    fp_next    = cmd.fp;
                    cur_next   = cmd.cur;
                    alt_next   = cmd.alt;
                    cnt_next   = '0;
                    ram_raddr  = cmd.cur;
                    state_next = S_CUR;
                end
            end
            S_CUR:
            begin
                cur_val_next = rd_slot;
                ram_raddr    = alt_reg;
                state_next   = S_ALT;
            end
            S_ALT:
            begin
                if (kind_reg == KIND_LOOKUP)
                begin
                    out_next.ok          = (cur_val_reg == fp_reg) || (rd_slot == fp_reg);
                    out_next.relocations = '0;
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
                else if (cur_val_reg == '0)
                begin
                    ram_we               = 1'b1;
                    ram_waddr            = cur_reg;
                    out_next.ok          = 1'b1;
                    out_next.relocations = '0;
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
                else if (rd_slot == '0)
                begin
                    ram_we               = 1'b1;
                    ram_waddr            = alt_reg;
                    out_next.ok          = 1'b1;
                    out_next.relocations = '0;
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
                else
                begin
                    // Both candidates are full: the new fingerprint takes the victim
                    // bucket and the old occupant is carried on.
                    ram_we    = 1'b1;
                    ram_waddr = pick_reg ? cur_reg : alt_reg;
                    cur_next  = pick_reg ? cur_reg : alt_reg;
                    fp_next   = pick_reg ? cur_val_reg : rd_slot;
                    if (fp_reg == '0)
                    begin
                        // A zero fingerprint just clears the victim; nothing relocates.
                        out_next.ok          = 1'b0;
                        out_next.relocations = '0;
                        out_valid_next       = 1'b1;
                        state_next           = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_REL_CHK;
                    end
                end
            end
            S_REL_CHK:
            begin
                if (cnt_reg < reloc_limit)
                begin
                    alt_next   = nxt_idx;
                    ram_raddr  = nxt_idx;
                    state_next = S_REL_RD;
                end
                else
                begin
                    out_next.ok          = 1'b0;
                    out_next.relocations = cnt_reg;
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            S_REL_RD:
            begin
                ram_we    = 1'b1;
                ram_waddr = alt_reg;
                if (rd_slot == '0)
                begin
                    out_next.ok          = 1'b1;
                    out_next.relocations = cnt_reg;
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
                else
                begin
                    fp_next    = rd_slot;
                    cur_next   = alt_reg;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_REL_CHK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (ram_we)
        begin
            valid_next[ram_waddr] = 1'b1;
        end
        valid_rd_next = valid_reg[ram_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= 1'b0;
            pick_reg      <= 1'b0;
            fp_reg        <= '0;
            cur_reg       <= '0;
            alt_reg       <= '0;
            cur_val_reg   <= '0;
            cnt_reg       <= '0;
            valid_reg     <= '0;
            valid_rd_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            pick_reg      <= pick_next;
            fp_reg        <= fp_next;
            cur_reg       <= cur_next;
            alt_reg       <= alt_next;
            cur_val_reg   <= cur_val_next;
            cnt_reg       <= cnt_next;
            valid_reg     <= valid_next;
            valid_rd_reg  <= valid_rd_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

endmodule

@@ rtl/cuckoo_filter_engine.sv @@
// Cuckoo filter engine: inserts and looks up 16-bit keys in a table of one
// fingerprint slot per bucket. The item side is a queue: a transfer happens
// when push is high and full is low. The result side is also a queue: the
// oldest result sits on the result port while empty is low and is transferred
// when pop is high. Every item yields exactly one result, in order.
// The front end hashes each key and holds up to two items; the back end walks
// the table through one single-port-read RAM. A lookup or a simple insert
// reads the current and the alternate bucket in the back end; an insert
// that evicts then repeats a relocation check and a read-then-swap step on
// the table memory, up to the relocation limit. An item's result reaches
// the result port through the front-end queue and the back end's idle,
// current-bucket and alternate-bucket states. The back end starts an item
// only once the result register is empty, so none starts while a result waits.
// Reset clears the table at once through per-bucket valid bits, empties both
// queues and sets the relocation limit to 8. When the receiver stalls, the
// result waits in its output register; the back end holds the next item until
// the result is taken, while the front end still takes up to two more items.
// The APB port holds the relocation limit at byte addresses 0 to 3; addresses
// 4 to 7 read as zero and ignore writes.
module cuckoo_filter_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  cfe_pkg::in_item_t             item,
    output logic                          full,
    output logic                          empty,
    output cfe_pkg::out_item_t            result,
    input  logic                          pop,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import cfe_pkg::*;

    localparam logic REG_MAX_RELOC = 1'b0;
    localparam logic [RELOC_W-1:0] MAX_RELOC_RESET = 8'd8;

    logic               cmd_valid;
    cmd_t               cmd;
    logic               cmd_pop;
    logic [RELOC_W-1:0] max_reloc_reg;
    logic               reg_index;
    logic               cfg_write;

    // The register index is the word address; the low two bits are ignored.
    assign reg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reloc_reg <= MAX_RELOC_RESET;
        end
        else if (cfg_write && (reg_index == REG_MAX_RELOC))
        begin
            max_reloc_reg <= pwdata[RELOC_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_index == REG_MAX_RELOC)
        begin
            prdata = {{(32-RELOC_W){1'b0}}, max_reloc_reg};
        end
    end

    cfe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .full     (full),
        .cmd_valid(cmd_valid),
        .cmd      (cmd),
        .cmd_pop  (cmd_pop)
    );

    cfe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop),
        .reloc_limit(max_reloc_reg),
        .empty      (empty),
        .result     (result),
        .pop        (pop)
    );

endmodule

@@ tb/sv/cuckoo_filter_engine_tb.sv @@
`timescale 1ns / 100ps

module cuckoo_filter_engine_tb;
    import cfe_pkg::*;

    // The slowest legal run is about 1050 items with up to 255 relocation steps
    // each, plus sender gaps and receiver stalls, so this limit leaves a wide
    // margin.
    localparam int CLK_PERIOD    = 10;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 16;

    localparam logic [2:0]         ADDR_MAX_RELOC  = 3'd0;
    localparam logic [2:0]         ADDR_UNMAPPED   = 3'd4;
    localparam logic [RELOC_W-1:0] MAX_RELOC_RESET = 8'd8;

    // The djb hash is computed here independently of the package.
    localparam int unsigned DJB_SEED = 5381;
    localparam int unsigned DJB_MULT = 33;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    in_item_t    item = '0;
    logic        full;
    logic        empty;
    out_item_t   result;
    logic        pop = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Shadow copy of the filter: the slot table and the relocation limit.
    fp_t                slot_shadow [BUCKET_COUNT] = '{default: '0};
    logic [RELOC_W-1:0] reloc_limit_shadow = MAX_RELOC_RESET;

    // Results predicted for accepted items, oldest first.
    out_item_t          expected_results[$];
    // Keys inserted recently; lookups draw from them so that hits are common.
    logic [KEY_W-1:0]   stored_keys[$];

    int error_count = 0;
    int cycle_count = 0;
    bit idle_on = 1'b1;
    int hold_cycles = 0;

    cuckoo_filter_engine dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .item    (item),
        .full    (full),
        .empty   (empty),
        .result  (result),
        .pop     (pop),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Two-byte djb hash, low byte first, wrapping at 16 bits.
    function automatic fp_t key_hash(input logic [KEY_W-1:0] v);
        int unsigned h;
        h = DJB_SEED;
        h = (h * DJB_MULT + v[7:0]) & 32'hFFFF;
        h = (h * DJB_MULT + v[15:8]) & 32'hFFFF;
        return fp_t'(h);
    endfunction

    function automatic idx_t home_bucket(input fp_t fp);
        return fp[IDX_W-1:0];
    endfunction

    // The other candidate bucket of a fingerprint that sits in bucket b.
    function automatic idx_t partner_bucket(input idx_t b, input fp_t fp);
        fp_t h;
        h = key_hash(fp);
        return b ^ h[IDX_W-1:0];
    endfunction

    // Applies one item to the shadow table and returns the result that the
    // block must produce for it.
    function automatic out_item_t filter_predict(input in_item_t it);
        fp_t                fp;
        fp_t                carry;
        fp_t                bumped;
        idx_t               home;
        idx_t               partner;
        idx_t               at;
        idx_t               nxt;
        logic [RELOC_W-1:0] swaps;
        logic               hit;
        out_item_t          r;
        fp = key_hash(it.key);
        home = home_bucket(fp);
        partner = partner_bucket(home, fp);
        hit = 1'b0;
        swaps = '0;
        if (it.kind == KIND_LOOKUP)
        begin
            hit = (slot_shadow[home] == fp) || (slot_shadow[partner] == fp);
        end
        else if (slot_shadow[home] == '0)
        begin
            slot_shadow[home] = fp;
            hit = 1'b1;
        end
        else if (slot_shadow[partner] == '0)
        begin
            slot_shadow[partner] = fp;
            hit = 1'b1;
        end
        else
        begin
            // Both candidates are taken: the new fingerprint displaces the
            // chosen victim, which then hops between its own two buckets.
            at = it.victim_pick ? home : partner;
            carry = slot_shadow[at];
            slot_shadow[at] = fp;
            if (fp != '0)
            begin
                while (!hit && swaps < reloc_limit_shadow)
                begin
                    nxt = partner_bucket(at, carry);
                    if (slot_shadow[nxt] == '0)
                    begin
                        slot_shadow[nxt] = carry;
                        hit = 1'b1;
                    end
                    else
                    begin
                        bumped = slot_shadow[nxt];
                        slot_shadow[nxt] = carry;
                        carry = bumped;
                        at = nxt;
                        swaps++;
                    end
                end
            end
            // A fingerprint still carried when the limit is hit is dropped.
        end
        r.ok = hit;
        r.relocations = swaps;
        return r;
    endfunction

    // Finds a key whose home bucket is the given one.
    function automatic logic [KEY_W-1:0] key_for_bucket(input idx_t target);
        logic [KEY_W-1:0] k;
        k = KEY_W'($urandom);
        for (int i = 0; i < (1 << KEY_W); i++)
        begin
            if (home_bucket(key_hash(k)) == target)
                return k;
            k = k + 1'b1;
        end
        return k;
    endfunction

    // Offers one item until it is transferred, then records its prediction.
    // push stays high afterwards unless an idle gap follows, so a following
    // call in the same time step keeps the stream back to back.
    task automatic send_item(input logic kind, input logic [KEY_W-1:0] key,
                             input logic pick);
        in_item_t it;
        int       gap;
        it.kind = kind;
        it.key = key;
        it.victim_pick = pick;
        push <= 1'b1;
        item <= it;
        do @(posedge clk); while (full);
        expected_results.push_back(filter_predict(it));
        if (kind == KIND_INSERT)
        begin
            stored_keys.push_back(key);
            if (stored_keys.size() > 200)
                void'(stored_keys.pop_front());
        end
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering items and waits until every predicted result has been
    // transferred, then lets the block settle.
    task automatic drain();
        push <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One APB transfer: a setup phase, then the access phase until pready,
    // then an idle phase before the port can be used again.
    task automatic apb_transfer(input logic write, input logic [2:0] addr,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        if (write && addr == ADDR_MAX_RELOC)
            reloc_limit_shadow = wdata[RELOC_W-1:0];
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic read_back_limit();
        logic [31:0] rd;
        apb_transfer(1'b0, ADDR_MAX_RELOC, '0, rd);
        if (rd !== 32'(reloc_limit_shadow))
        begin
            $display("%0t: relocation limit read back: expected %0d, actual %0d",
                     $time, reloc_limit_shadow, rd);
            error_count++;
        end
    endtask

    // The register is only written while the block is idle.
    task automatic set_limit(input logic [RELOC_W-1:0] value);
        logic [31:0] rd;
        drain();
        apb_transfer(1'b1, ADDR_MAX_RELOC, {8'($urandom_range(0, 255)), 16'h0, value}, rd);
        reloc_limit_shadow = value;
        read_back_limit();
    endtask

    // Puts some fingerprint into an empty bucket by inserting a key that
    // hashes there.
    task automatic fill_bucket(input idx_t b);
        if (slot_shadow[b] == '0)
            send_item(KIND_INSERT, key_for_bucket(b), 1'($urandom_range(0, 1)));
    endtask

    // Mix of inserts, lookups of stored keys and lookups of random keys.
    task automatic random_item();
        int               roll;
        logic             kind;
        logic [KEY_W-1:0] k;
        roll = $urandom_range(0, 99);
        if (roll < 22)
        begin
            kind = KIND_INSERT;
            k = KEY_W'($urandom);
        end
        else if (roll < 70 && stored_keys.size() > 0)
        begin
            kind = KIND_LOOKUP;
            k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        end
        else
        begin
            kind = KIND_LOOKUP;
            k = KEY_W'($urandom);
        end
        send_item(kind, k, 1'($urandom_range(0, 1)));
    endtask

    // Reset value, both extremes, and a write to an unmapped address that
    // must leave the register alone.
    task automatic test_register_access();
        logic [31:0] rd;
        read_back_limit();
        set_limit(8'd0);
        set_limit(8'd255);
        apb_transfer(1'b1, ADDR_UNMAPPED, $urandom, rd);
        read_back_limit();
        set_limit(MAX_RELOC_RESET);
    endtask

    // Extreme keys, both operations, both victim choices, and a key stored
    // three times so that the third copy has to evict and relocate.
    task automatic test_basic_ops();
        send_item(KIND_INSERT, 16'h0000, 1'b0);
        send_item(KIND_INSERT, 16'hFFFF, 1'b1);
        send_item(KIND_LOOKUP, 16'h0000, 1'b0);
        send_item(KIND_LOOKUP, 16'hFFFF, 1'b1);
        send_item(KIND_LOOKUP, KEY_W'($urandom), 1'b0);
        send_item(KIND_INSERT, 16'h0000, 1'b1);
        send_item(KIND_INSERT, 16'h0000, 1'b0);
        send_item(KIND_LOOKUP, 16'h0000, 1'b1);
        drain();
    endtask

    // With a limit of zero every eviction fails at once; with the largest
    // limit the displaced fingerprints walk the table.
    task automatic test_relocation_limit();
        logic [KEY_W-1:0] k;
        fp_t              fp;
        idx_t             home;
        idx_t             partner;
        set_limit(8'd0);
        do
        begin
            k = KEY_W'($urandom);
            fp = key_hash(k);
            home = home_bucket(fp);
            partner = partner_bucket(home, fp);
        end
        while (home == partner);
        fill_bucket(home);
        fill_bucket(partner);
        send_item(KIND_INSERT, k, 1'b0);
        send_item(KIND_INSERT, k, 1'b1);
        send_item(KIND_LOOKUP, k, 1'b0);
        set_limit(8'd255);
        repeat (4) send_item(KIND_INSERT, k, 1'($urandom_range(0, 1)));
        send_item(KIND_LOOKUP, k, 1'b1);
        drain();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering items back to back, so the block fills and raises full.
    task automatic test_backpressure();
        idle_on = 1'b0;
        hold_cycles = 200;
        repeat (16) random_item();
        drain();
        idle_on = 1'b1;
    endtask

    task automatic run_random(input int count, input logic [RELOC_W-1:0] limit,
                              input bit idle);
        set_limit(limit);
        idle_on = idle;
        repeat (count) random_item();
    endtask

    // Result side: checks each transfer against the oldest prediction and
    // decides pop for the next cycle, with random stall bursts and the long
    // hold-off that the back-pressure test asks for.
    initial
    begin : result_side
        int        stall_left;
        out_item_t want;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual ok=%0b relocations=%0d",
                             $time, result.ok, result.relocations);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.ok !== want.ok)
                    begin
                        $display("%0t: ok mismatch: expected %0b, actual %0b",
                                 $time, want.ok, result.ok);
                        error_count++;
                    end
                    if (result.relocations !== want.relocations)
                    begin
                        $display("%0t: relocations mismatch: expected %0d, actual %0d",
                                 $time, want.relocations, result.relocations);
                        error_count++;
                    end
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                pop <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                // Starts a burst of stalled cycles, this one included.
                stall_left = $urandom_range(0, 8);
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_register_access();
        test_basic_ops();
        test_relocation_limit();
        test_backpressure();

        // Random phases over a spread of relocation limits. Inserts are a
        // minority, so the table fills gradually across the phases. The last
        // phase runs without idling on either side.
        run_random(300, MAX_RELOC_RESET, 1'b1);
        run_random(200, 8'd1, 1'b1);
        run_random(100, 8'd255, 1'b1);
        run_random(100, 8'd0, 1'b1);
        run_random(150, 8'($urandom_range(2, 30)), 1'b1);
        run_random(150, MAX_RELOC_RESET, 1'b0);
        drain();

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
